// ===== hw/rtl/lts_pkg.sv =====
// ----------------------------------------------------------------------------
// lts_pkg
// Shared types, token codes and character helpers for the Lox token scanner.
// ----------------------------------------------------------------------------
package lts_pkg;

  localparam int OFFSET_BITS_DEF   = 24;
  localparam int KEYWORD_CHARS_DEF = 6;
  localparam int FIELD_BITS        = 24;
  localparam int CALC_BITS         = 32;
  localparam int KW_MATCH_CHARS    = 6;
  localparam int TOKENS_PER_WORD   = 3;
  localparam int QUEUE_DEPTH       = 8;

  localparam logic [7:0] CHAR_CR   = 8'h0D;

  typedef enum logic [5:0] {
    K_LEFT_PAREN    = 6'd0,
    K_RIGHT_PAREN   = 6'd1,
    K_LEFT_BRACE    = 6'd2,
    K_RIGHT_BRACE   = 6'd3,
    K_COMMA         = 6'd4,
    K_DOT           = 6'd5,
    K_MINUS         = 6'd6,
    K_PLUS          = 6'd7,
    K_SEMICOLON     = 6'd8,
    K_SLASH         = 6'd9,
    K_STAR          = 6'd10,
    K_BANG          = 6'd11,
    K_BANG_EQUAL    = 6'd12,
    K_EQUAL         = 6'd13,
    K_EQUAL_EQUAL   = 6'd14,
    K_GREATER       = 6'd15,
    K_GREATER_EQUAL = 6'd16,
    K_LESS          = 6'd17,
    K_LESS_EQUAL    = 6'd18,
    K_IDENTIFIER    = 6'd19,
    K_STRING        = 6'd20,
    K_NUMBER        = 6'd21,
    K_AND           = 6'd22,
    K_CLASS         = 6'd23,
    K_ELSE          = 6'd24,
    K_FALSE         = 6'd25,
    K_FOR           = 6'd26,
    K_FUN           = 6'd27,
    K_IF            = 6'd28,
    K_NIL           = 6'd29,
    K_OR            = 6'd30,
    K_PRINT         = 6'd31,
    K_RETURN        = 6'd32,
    K_SUPER         = 6'd33,
    K_THIS          = 6'd34,
    K_TRUE          = 6'd35,
    K_VAR           = 6'd36,
    K_WHILE         = 6'd37,
    K_ERROR         = 6'd38,
    K_EOF           = 6'd39
  } kind_t;

  typedef enum logic [3:0] {
    M_IDLE,
    M_SLASH,
    M_COMMENT,
    M_OP,
    M_IDENT,
    M_NUMBER,
    M_NUMDOT,
    M_FRACTION,
    M_STRING
  } mode_t;

  typedef enum logic {
    ERR_UNEXPECTED   = 1'b0,
    ERR_UNTERMINATED = 1'b1
  } err_t;

  typedef struct packed {
    kind_t                  kind;
    logic [FIELD_BITS-1:0]  start;
    logic [FIELD_BITS-1:0]  length;
    logic [FIELD_BITS-1:0]  line;
    err_t                   code;
    logic                   last;
  } token_t;

  // Up to three tokens handed from the scanner to the queue in one cycle.
  typedef struct packed {
    logic [1:0]                    count;
    token_t [TOKENS_PER_WORD-1:0]  tok;
  } push_t;

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic kind_t op_kind(logic [7:0] c, logic with_equal);
    kind_t k;
    case (c)
      "!":     k = with_equal ? K_BANG_EQUAL : K_BANG;
      "=":     k = with_equal ? K_EQUAL_EQUAL : K_EQUAL;
      ">":     k = with_equal ? K_GREATER_EQUAL : K_GREATER;
      default: k = with_equal ? K_LESS_EQUAL : K_LESS;
    endcase
    return k;
  endfunction

  // The word holds the first characters of the identifier, first one on top.
  function automatic kind_t keyword_kind(logic [8*KW_MATCH_CHARS-1:0] w, logic [3:0] fill);
    kind_t k;
    k = K_IDENTIFIER;
    case (fill)
      4'd2: begin
        if (w[47:32] == "if") k = K_IF;
        else if (w[47:32] == "or") k = K_OR;
      end
      4'd3: begin
        if (w[47:24] == "and") k = K_AND;
        else if (w[47:24] == "for") k = K_FOR;
        else if (w[47:24] == "fun") k = K_FUN;
        else if (w[47:24] == "nil") k = K_NIL;
        else if (w[47:24] == "var") k = K_VAR;
      end
      4'd4: begin
        if (w[47:16] == "else") k = K_ELSE;
        else if (w[47:16] == "this") k = K_THIS;
        else if (w[47:16] == "true") k = K_TRUE;
      end
      4'd5: begin
        if (w[47:8] == "class") k = K_CLASS;
        else if (w[47:8] == "false") k = K_FALSE;
        else if (w[47:8] == "print") k = K_PRINT;
        else if (w[47:8] == "super") k = K_SUPER;
        else if (w[47:8] == "while") k = K_WHILE;
      end
      4'd6: begin
        if (w == "return") k = K_RETURN;
      end
      default: ;
    endcase
    return k;
  endfunction

  function automatic token_t make_token(kind_t k, logic [CALC_BITS-1:0] start,
                                        logic [CALC_BITS-1:0] len, err_t code,
                                        logic [FIELD_BITS-1:0] line);
    token_t t;
    t.kind   = k;
    t.start  = start[FIELD_BITS-1:0];
    t.length = (|len[CALC_BITS-1:FIELD_BITS]) ? {FIELD_BITS{1'b1}} : len[FIELD_BITS-1:0];
    t.line   = line;
    t.code   = code;
    t.last   = 1'b0;
    return t;
  endfunction

endpackage

// ===== hw/rtl/lts_scanner.sv =====
// ----------------------------------------------------------------------------
// lts_scanner
// Input register plus scanner state; decides up to three tokens per byte.
// ----------------------------------------------------------------------------
module lts_scanner import lts_pkg::*; #(
  parameter int OFFSET_BITS   = OFFSET_BITS_DEF,
  parameter int KEYWORD_CHARS = KEYWORD_CHARS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_source_byte,
  input  logic        in_end_of_source,
  input  logic        room,
  output push_t       push
);

  localparam int FILL_BITS = $clog2(KEYWORD_CHARS + 2);

  logic                      stage_valid_r, stage_valid_nxt;
  logic [7:0]                byte_r;
  logic                      eos_r;
  mode_t                     mode_r, mode_nxt;
  logic [7:0]                pend_r, pend_nxt;
  logic [7:0]                prefix_r   [KEYWORD_CHARS];
  logic [7:0]                prefix_nxt [KEYWORD_CHARS];
  logic [FILL_BITS-1:0]      fill_r, fill_nxt;
  logic [OFFSET_BITS-1:0]    pos_r, pos_nxt;
  logic [OFFSET_BITS-1:0]    begin_r, begin_nxt;
  logic [FIELD_BITS-1:0]     line_r, line_nxt;

  logic                      fire, accept;
  logic [CALC_BITS-1:0]      pos32, begin32;
  logic [8*KW_MATCH_CHARS-1:0] kw_word;
  logic [FIELD_BITS-1:0]     line_bumped;
  token_t                    fa, fb, tok_a, tok_b, tok_c;
  logic                      vfa, vfb, va, vb, vc;
  logic                      do_flush, do_disp;
  logic [1:0]                n_tok;

  assign fire     = stage_valid_r && room;
  assign in_ready = !stage_valid_r || room;
  assign accept   = in_valid && in_ready;
  assign pos32    = CALC_BITS'(pos_r);
  assign begin32  = CALC_BITS'(begin_r);
  assign line_bumped = (line_r == {FIELD_BITS{1'b1}}) ? line_r : line_r + 1'b1;

  always_comb begin
    for (int i = 0; i < KW_MATCH_CHARS; i++) begin
      kw_word[8*(KW_MATCH_CHARS-i)-1 -: 8] = prefix_r[i];
    end
  end

  // Tokens released when the pending token is closed at the current position.
  always_comb begin
    fa  = '0;
    fb  = '0;
    vfa = 1'b0;
    vfb = 1'b0;
    case (mode_r)
      M_SLASH: begin
        vfa = 1'b1;
        fa  = make_token(K_SLASH, begin32, CALC_BITS'(1), ERR_UNEXPECTED, line_r);
      end
      M_OP: begin
        vfa = 1'b1;
        fa  = make_token(op_kind(pend_r, 1'b0), begin32, CALC_BITS'(1), ERR_UNEXPECTED,
                         line_r);
      end
      M_IDENT: begin
        vfa = 1'b1;
        fa  = make_token(keyword_kind(kw_word, 4'(fill_r)), begin32, pos32 - begin32,
                         ERR_UNEXPECTED, line_r);
      end
      M_NUMBER, M_FRACTION: begin
        vfa = 1'b1;
        fa  = make_token(K_NUMBER, begin32, pos32 - begin32, ERR_UNEXPECTED, line_r);
      end
      M_NUMDOT: begin
        // The trailing dot was not followed by a digit, so it stands alone.
        vfa = 1'b1;
        vfb = 1'b1;
        fa  = make_token(K_NUMBER, begin32, pos32 - 1'b1 - begin32, ERR_UNEXPECTED, line_r);
        fb  = make_token(K_DOT, pos32 - 1'b1, CALC_BITS'(1), ERR_UNEXPECTED, line_r);
      end
      M_STRING: begin
        vfa = 1'b1;
        fa  = make_token(K_ERROR, begin32, pos32 - begin32, ERR_UNTERMINATED, line_r);
      end
      default: ;
    endcase
  end

  always_comb begin
    mode_nxt   = mode_r;
    pend_nxt   = pend_r;
    prefix_nxt = prefix_r;
    fill_nxt   = fill_r;
    pos_nxt    = pos_r;
    begin_nxt  = begin_r;
    line_nxt   = line_r;
    tok_c      = '0;
    vc         = 1'b0;
    do_flush   = 1'b0;
    do_disp    = 1'b0;

    if (eos_r) begin
      do_flush = 1'b1;
      vc       = 1'b1;
      tok_c    = make_token(K_EOF, pos32, '0, ERR_UNEXPECTED, line_r);
      mode_nxt = M_IDLE;
      pend_nxt = '0;
      for (int i = 0; i < KEYWORD_CHARS; i++) prefix_nxt[i] = '0;
      fill_nxt  = '0;
      pos_nxt   = '0;
      begin_nxt = '0;
      line_nxt  = FIELD_BITS'(1);
    end else begin
      if (pos_r != {OFFSET_BITS{1'b1}}) pos_nxt = pos_r + 1'b1;

      case (mode_r)
        M_SLASH: begin
          if (byte_r == "/") mode_nxt = M_COMMENT;
          else do_disp = 1'b1;
        end
        M_COMMENT: begin
          if (byte_r == "\n") do_disp = 1'b1;
        end
        M_OP: begin
          if (byte_r == "=") begin
            vc       = 1'b1;
            tok_c    = make_token(op_kind(pend_r, 1'b1), begin32, pos32 + 1'b1 - begin32,
                                  ERR_UNEXPECTED, line_r);
            mode_nxt = M_IDLE;
          end else begin
            do_disp = 1'b1;
          end
        end
        M_IDENT: begin
          if (is_alpha(byte_r) || is_digit(byte_r)) begin
            for (int i = 0; i < KEYWORD_CHARS; i++) begin
              if (FILL_BITS'(i) == fill_r) prefix_nxt[i] = byte_r;
            end
            if (fill_r <= FILL_BITS'(KEYWORD_CHARS)) fill_nxt = fill_r + 1'b1;
          end else begin
            do_disp = 1'b1;
          end
        end
        M_NUMBER: begin
          if (byte_r == ".") mode_nxt = M_NUMDOT;
          else if (!is_digit(byte_r)) do_disp = 1'b1;
        end
        M_NUMDOT: begin
          if (is_digit(byte_r)) mode_nxt = M_FRACTION;
          else do_disp = 1'b1;
        end
        M_FRACTION: begin
          if (!is_digit(byte_r)) do_disp = 1'b1;
        end
        M_STRING: begin
          if (byte_r == "\"") begin
            vc       = 1'b1;
            tok_c    = make_token(K_STRING, begin32, pos32 + 1'b1 - begin32,
                                  ERR_UNEXPECTED, line_r);
            mode_nxt = M_IDLE;
          end else if (byte_r == "\n") begin
            line_nxt = line_bumped;
          end
        end
        default: do_disp = 1'b1;
      endcase

      if (do_disp) begin
        do_flush  = 1'b1;
        mode_nxt  = M_IDLE;
        begin_nxt = pos_r;
        if (is_alpha(byte_r)) begin
          for (int i = 0; i < KEYWORD_CHARS; i++) prefix_nxt[i] = '0;
          prefix_nxt[0] = byte_r;
          fill_nxt      = FILL_BITS'(1);
          mode_nxt      = M_IDENT;
        end else if (is_digit(byte_r)) begin
          mode_nxt = M_NUMBER;
        end else begin
          vc    = 1'b1;
          tok_c = make_token(K_ERROR, pos32, CALC_BITS'(1), ERR_UNEXPECTED, line_r);
          case (byte_r)
            " ", CHAR_CR, "\t": vc = 1'b0;
            "\n": begin
              vc       = 1'b0;
              line_nxt = line_bumped;
            end
            "(": tok_c.kind = K_LEFT_PAREN;
            ")": tok_c.kind = K_RIGHT_PAREN;
            "{": tok_c.kind = K_LEFT_BRACE;
            "}": tok_c.kind = K_RIGHT_BRACE;
            ",": tok_c.kind = K_COMMA;
            ".": tok_c.kind = K_DOT;
            "-": tok_c.kind = K_MINUS;
            "+": tok_c.kind = K_PLUS;
            ";": tok_c.kind = K_SEMICOLON;
            "*": tok_c.kind = K_STAR;
            "/": begin
              vc       = 1'b0;
              mode_nxt = M_SLASH;
            end
            "!", "=", "<", ">": begin
              vc       = 1'b0;
              pend_nxt = byte_r;
              mode_nxt = M_OP;
            end
            "\"": begin
              vc       = 1'b0;
              mode_nxt = M_STRING;
            end
            default: ;
          endcase
        end
      end
    end
  end

  assign va    = do_flush && vfa;
  assign vb    = do_flush && vfb;
  assign tok_a = fa;
  assign tok_b = fb;
  assign n_tok = {1'b0, va} + {1'b0, vb} + {1'b0, vc};

  // Pack the valid tokens in order and mark the final one of this byte.
  always_comb begin
    push.tok = '0;
    if (va) begin
      push.tok[0] = tok_a;
      if (vb) begin
        push.tok[1] = tok_b;
        push.tok[2] = tok_c;
      end else begin
        push.tok[1] = tok_c;
      end
    end else begin
      push.tok[0] = tok_c;
    end
    if (n_tok != 2'd0) push.tok[n_tok - 2'd1].last = 1'b1;
    push.count = fire ? n_tok : 2'd0;
  end

  always_comb begin
    stage_valid_nxt = stage_valid_r;
    if (accept) stage_valid_nxt = 1'b1;
    else if (fire) stage_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r <= in_source_byte;
      eos_r  <= in_end_of_source;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
      mode_r        <= M_IDLE;
      pend_r        <= '0;
      for (int i = 0; i < KEYWORD_CHARS; i++) prefix_r[i] <= '0;
      fill_r        <= '0;
      pos_r         <= '0;
      begin_r       <= '0;
      line_r        <= FIELD_BITS'(1);
    end else begin
      stage_valid_r <= stage_valid_nxt;
      if (fire) begin
        mode_r   <= mode_nxt;
        pend_r   <= pend_nxt;
        prefix_r <= prefix_nxt;
        fill_r   <= fill_nxt;
        pos_r    <= pos_nxt;
        begin_r  <= begin_nxt;
        line_r   <= line_nxt;
      end
    end
  end

endmodule

// ===== hw/rtl/lts_token_fifo.sv =====
// ----------------------------------------------------------------------------
// lts_token_fifo
// Small result queue that takes up to three tokens a cycle and hands out one while out_ready is high.
// ----------------------------------------------------------------------------
module lts_token_fifo import lts_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  push_t   push,
  output logic    room,
  output logic    out_valid,
  input  logic    out_ready,
  output token_t  head
);

  localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  token_t                entry_r [QUEUE_DEPTH];
  logic [PTR_BITS-1:0]   head_r, head_nxt;
  logic [PTR_BITS-1:0]   tail_r, tail_nxt;
  logic [CNT_BITS-1:0]   count_r, count_nxt;
  logic                  pop;

  assign out_valid = (count_r != '0);
  assign pop       = out_valid && out_ready;
  assign head      = entry_r[head_r];

  // A full burst of three must fit after this cycle's pop.
  assign room = (count_r <= CNT_BITS'(QUEUE_DEPTH - TOKENS_PER_WORD) + CNT_BITS'(pop));

  always_comb begin
    head_nxt  = head_r + PTR_BITS'(pop);
    tail_nxt  = tail_r + PTR_BITS'(push.count);
    count_nxt = count_r + CNT_BITS'(push.count) - CNT_BITS'(pop);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < TOKENS_PER_WORD; i++) begin
      if (2'(i) < push.count) entry_r[tail_r + PTR_BITS'(i)] <= push.tok[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

// ===== hw/rtl/lox_token_scanner_core.sv =====
// Input: a byte is registered on acceptance, and its tokens are written into the result
// queue once the queue has room; the first token is presented at the queue head.
// Throughput: one source byte per cycle; the scanner stalls only when the 8-entry
// result queue cannot take a burst of three tokens after the current pop.
// Reset (synchronous, rst_n low): scanner idle, positions zero, line count one,
// result queue empty.
// ----------------------------------------------------------------------------
// lox_token_scanner_core
// Streaming Lox lexical scanner: source bytes in, tokens out.
// ----------------------------------------------------------------------------
module lox_token_scanner_core import lts_pkg::*; #(
  parameter int OFFSET_BITS   = OFFSET_BITS_DEF,
  parameter int KEYWORD_CHARS = KEYWORD_CHARS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             in_source_byte,
  input  logic                   in_end_of_source,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [5:0]             out_token_kind,
  output logic [FIELD_BITS-1:0]  out_start_offset,
  output logic [FIELD_BITS-1:0]  out_token_length,
  output logic [FIELD_BITS-1:0]  out_line_number,
  output logic                   out_error_code,
  output logic                   out_last_of_run
);

  push_t  push;
  logic   room;
  token_t head;

  lts_scanner #(
    .OFFSET_BITS   (OFFSET_BITS),
    .KEYWORD_CHARS (KEYWORD_CHARS)
  ) u_scanner (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_source_byte   (in_source_byte),
    .in_end_of_source (in_end_of_source),
    .room             (room),
    .push             (push)
  );

  lts_token_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign out_token_kind   = head.kind;
  assign out_start_offset = head.start;
  assign out_token_length = head.length;
  assign out_line_number  = head.line;
  assign out_error_code   = head.code;
  assign out_last_of_run  = head.last;

endmodule
